/* design/channel_time_walk_correction_macros.svh */
// Assertion macros for the time-walk correction block.
// Included by the top level; no other dependencies.
`ifndef CHANNEL_TIME_WALK_CORRECTION_MACROS_SVH
`define CHANNEL_TIME_WALK_CORRECTION_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every edge out of reset
`define CTWC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ctwc check failed");
// Antecedent implies consequent in the same cycle
`define CTWC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctwc check failed");
// Antecedent implies consequent in the next cycle
`define CTWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctwc check failed");
`else
`define CTWC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define CTWC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CTWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/ctwc_pkg.sv */
// Shared types, codes and saturation helpers for the time-walk correction block.
// No dependencies.
`default_nettype none
package ctwc_pkg;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_FWD  = 2'd1;
    localparam logic [1:0] ACT_REV  = 2'd2;

    localparam logic [1:0] TYPE_NONE  = 2'd0;
    localparam logic [1:0] TYPE_ISQ   = 2'd1;
    localparam logic [1:0] TYPE_POLY  = 2'd2;
    localparam logic [1:0] TYPE_UNSUP = 2'd3;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_ISQ  = 2'd1;
    localparam logic [1:0] MODE_POLY = 2'd2;

    localparam int KEY_W    = 28;
    localparam int SQ_ST    = 12;
    localparam int DV_ST    = 16;
    localparam int INV_LAT  = SQ_ST + DV_ST + 2;
    localparam int POLY_LAT = 6;

    typedef logic signed [31:0] t_q16;

    typedef struct packed {
        logic [1:0] ctype;
        t_q16       a;
        t_q16       b;
        t_q16       c;
    } t_coef;

    typedef struct packed {
        logic lookup;
        logic rev;
        logic hit;
        logic load_ok;
        logic full;
        t_q16 t;
        t_q16 h;
    } t_s0;

    typedef struct packed {
        logic       rev;
        logic [1:0] mode;
        logic       found;
        logic       unk;
        logic       full;
        t_q16       t;
        t_q16       c;
    } t_side;

    // Clip a 33-bit sum to 32 bits
    function automatic t_q16 sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Q32.32 product to Q16.16, floor, clipped
    function automatic t_q16 qsat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        if (!((&s[63:31]) || !(|s[63:31]))) begin
            return s[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage
`default_nettype wire

/* design/ctwc_inv_sqrt.sv */
// Pipelined a / sqrt(|h - b|) in Q16.16: square root then division, two bits a stage.
// Depends on ctwc_pkg. Every stage advances only while i_en is high.
`default_nettype none
module ctwc_inv_sqrt (
    input  logic          i_clk,
    input  logic          i_en,
    input  ctwc_pkg::t_q16 i_h,
    input  ctwc_pkg::t_q16 i_b,
    input  ctwc_pkg::t_q16 i_a,
    output ctwc_pkg::t_q16 o_term
);
    import ctwc_pkg::*;

    typedef struct packed {
        logic [25:0] rem;
        logic [23:0] root;
    } t_sq;

    typedef struct packed {
        logic [23:0] rem;
        logic [31:0] q;
        logic [31:0] n;
        logic [23:0] s;
        logic        ovf;
        logic        neg;
    } t_dv;

    function automatic t_sq sq_step(input t_sq cur, input logic [1:0] bits);
        logic [27:0] w;
        logic [27:0] tr;
        t_sq         nx;
        w  = {cur.rem, bits};
        tr = {2'b00, cur.root, 2'b01};
        if (w >= tr) begin
            nx.rem  = 26'(w - tr);
            nx.root = {cur.root[22:0], 1'b1};
        end else begin
            nx.rem  = w[25:0];
            nx.root = {cur.root[22:0], 1'b0};
        end
        return nx;
    endfunction

    function automatic t_dv dv_step(input t_dv cur);
        logic [24:0] w;
        t_dv         nx;
        nx   = cur;
        w    = {cur.rem, cur.n[31]};
        nx.n = {cur.n[30:0], 1'b0};
        if (w >= {1'b0, cur.s}) begin
            nx.rem = 24'(w - {1'b0, cur.s});
            nx.q   = {cur.q[30:0], 1'b1};
        end else begin
            nx.rem = w[23:0];
            nx.q   = {cur.q[30:0], 1'b0};
        end
        return nx;
    endfunction

    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [31:0]        a_mag;

    logic [47:0] r_x  [0:SQ_ST];
    t_sq         r_sq [0:SQ_ST];
    logic [31:0] r_am [0:SQ_ST];
    logic        r_an [0:SQ_ST];
    t_dv         r_dv [1:DV_ST];
    t_dv         n_dv_init;
    t_q16        r_term;

    // Difference magnitude, zero clamped to one LSB
    always_comb begin
        diff = 33'(i_h) - 33'(i_b);
        mag  = diff[32] ? 32'(-diff) : diff[31:0];
        if (mag == '0) begin
            mag = 32'd1;
        end
        a_mag = i_a[31] ? 32'(-i_a) : 32'(i_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= {mag, 16'd0};
            r_sq[0] <= '0;
            r_am[0] <= a_mag;
            r_an[0] <= i_a[31];
        end
    end

    // Square root, two result bits a stage
    genvar k;
    for (k = 1; k <= SQ_ST; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]  <= r_x[k-1] << 4;
                r_sq[k] <= sq_step(sq_step(r_sq[k-1], r_x[k-1][47:46]), r_x[k-1][45:44]);
                r_am[k] <= r_am[k-1];
                r_an[k] <= r_an[k-1];
            end
        end
    end

    // Seed the divider; quotient of 2^32 or more only flags overflow
    always_comb begin
        n_dv_init.rem = 24'(r_am[SQ_ST][31:16]);
        n_dv_init.q   = '0;
        n_dv_init.n   = {r_am[SQ_ST][15:0], 16'd0};
        n_dv_init.s   = r_sq[SQ_ST].root;
        n_dv_init.ovf = 24'(r_am[SQ_ST][31:16]) >= r_sq[SQ_ST].root;
        n_dv_init.neg = r_an[SQ_ST];
    end

    // Restoring division, two quotient bits a stage
    for (k = 1; k <= DV_ST; k++) begin : g_dv
        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[k] <= dv_step(dv_step(n_dv_init));
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[k] <= dv_step(dv_step(r_dv[k-1]));
                end
            end
        end
    end

    // Apply sign of a and clip
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dv[DV_ST].neg) begin
                r_term <= (r_dv[DV_ST].ovf || r_dv[DV_ST].q > 32'h8000_0000)
                          ? 32'sh8000_0000 : t_q16'(-r_dv[DV_ST].q);
            end else begin
                r_term <= (r_dv[DV_ST].ovf || r_dv[DV_ST].q[31])
                          ? 32'sh7FFF_FFFF : t_q16'(r_dv[DV_ST].q);
            end
        end
    end

    assign o_term = r_term;

endmodule
`default_nettype wire

/* design/channel_time_walk_correction.sv */
// One beat per cycle sustained while the output is not stalled.
// Key match and table write share the first stage, so a lookup sees any earlier load.
// The inverse square root unit (12 root stages, 16 divide stages) sets the depth.
// A stall while the output holds a beat freezes the whole pipeline; the output register holds the beat.
// Synchronous active-low reset empties the table and the pipeline at once.
`default_nettype none
`include "channel_time_walk_correction_macros.svh"
module channel_time_walk_correction #(
    parameter int ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_channel_id,
    input  logic [7:0]         i_plane_id,
    input  logic [9:0]         i_segment,
    input  logic [1:0]         i_side,
    input  logic [1:0]         i_corr_type,
    input  logic signed [31:0] i_coef_a,
    input  logic signed [31:0] i_coef_b,
    input  logic signed [31:0] i_coef_c,
    input  logic signed [31:0] i_time_value,
    input  logic signed [31:0] i_pulse_height,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_corrected_time,
    output logic               o_found,
    output logic               o_unknown_type,
    output logic               o_table_full
);
    import ctwc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PD_N  = INV_LAT - POLY_LAT;

    logic en;
    logic accept;
    logic is_load;
    logic is_lookup;
    logic [KEY_W-1:0] key_in;
    logic [ENTRIES-1:0] hit_vec;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] wr_idx;
    logic hit_any;
    logic free_any;
    logic load_ok;

    logic [ENTRIES-1:0] r_ent_valid;
    logic [KEY_W-1:0]   r_ent_key [ENTRIES];
    t_coef              r_mem [ENTRIES];
    t_coef              r_mem_q;

    logic  r_s0_valid;
    t_s0   r_s0;
    t_side n_side;
    logic  r_side_v [0:INV_LAT-1];
    t_side r_side   [0:INV_LAT-1];
    t_q16  inv_term;

    logic signed [63:0] r_p1;
    t_q16 r_p1_a, r_p1_b, r_p1_c, r_p1_h;
    t_q16 r_p2_hh, r_p2_a, r_p2_b, r_p2_c, r_p2_h;
    logic signed [63:0] r_p3_ah, r_p3_bh;
    t_q16 r_p3_c;
    t_q16 r_p4_qa, r_p4_qb, r_p4_c;
    t_q16 r_p5_s, r_p5_c;
    t_q16 r_p6_poly;
    t_q16 r_pd [0:PD_N-1];

    t_side n_f1_side;
    t_q16  n_f1_mid;
    logic  r_f1_valid;
    t_side r_f1_side;
    t_q16  r_f1_mid;
    t_q16  n_out_time;

    logic r_out_valid;
    t_q16 r_out_time;
    logic r_out_found;
    logic r_out_unk;
    logic r_out_full;

    // Advance only when the output register is free or being drained
    assign en      = !(r_out_valid && i_stall);
    assign accept  = i_valid && en;
    assign o_stall = !en;

    assign is_load   = (i_action == ACT_LOAD);
    assign is_lookup = (i_action == ACT_FWD) || (i_action == ACT_REV);
    assign key_in    = {i_side, i_plane_id, i_channel_id, i_segment};

    // Match key in every entry; pick lowest hit and lowest free entry
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_ent_valid[i] && (r_ent_key[i] == key_in);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_ent_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        hit_any  = |hit_vec;
        free_any = !(&r_ent_valid);
        load_ok  = hit_any || free_any;
        wr_idx   = hit_any ? hit_idx : free_idx;
    end

    // Entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
        end else if (accept && is_load && load_ok) begin
            r_ent_valid[wr_idx] <= 1'b1;
        end
    end

    // Keys and coefficient memory: write on load, registered read at hit
    always_ff @(posedge i_clk) begin
        if (accept && is_load && load_ok) begin
            r_ent_key[wr_idx] <= key_in;
            r_mem[wr_idx]     <= '{ctype: i_corr_type, a: i_coef_a, b: i_coef_b, c: i_coef_c};
        end
        if (en) begin
            r_mem_q <= r_mem[hit_idx];
        end
    end

    // First stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.lookup  <= is_lookup;
            r_s0.rev     <= (i_action == ACT_REV);
            r_s0.hit     <= hit_any;
            r_s0.load_ok <= is_load && load_ok;
            r_s0.full    <= is_load && !load_ok;
            r_s0.t       <= i_time_value;
            r_s0.h       <= i_pulse_height;
        end
    end

    // Decode the looked-up entry into the sideband
    always_comb begin
        n_side.rev   = r_s0.rev;
        n_side.mode  = MODE_PASS;
        n_side.found = r_s0.lookup ? r_s0.hit : r_s0.load_ok;
        n_side.unk   = r_s0.lookup && r_s0.hit && (r_mem_q.ctype == TYPE_UNSUP);
        n_side.full  = r_s0.full;
        n_side.t     = r_s0.lookup ? r_s0.t : '0;
        n_side.c     = r_mem_q.c;
        if (r_s0.lookup && r_s0.hit) begin
            if (r_mem_q.ctype == TYPE_ISQ) begin
                n_side.mode = MODE_ISQ;
            end else if (r_mem_q.ctype == TYPE_POLY) begin
                n_side.mode = MODE_POLY;
            end
        end
    end

    // Sideband delay line, matched to the inverse square root unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INV_LAT; i++) begin
                r_side_v[i] <= 1'b0;
            end
        end else if (en) begin
            r_side_v[0] <= r_s0_valid;
            for (int i = 1; i < INV_LAT; i++) begin
                r_side_v[i] <= r_side_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int i = 1; i < INV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    ctwc_inv_sqrt u_inv_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_h    (r_s0.h),
        .i_b    (r_mem_q.b),
        .i_a    (r_mem_q.a),
        .o_term (inv_term)
    );

    // Quadratic: h*h, then a*hh and b*h, then the sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1    <= r_s0.h * r_s0.h;
            r_p1_a  <= r_mem_q.a;
            r_p1_b  <= r_mem_q.b;
            r_p1_c  <= r_mem_q.c;
            r_p1_h  <= r_s0.h;
            r_p2_hh <= qsat(r_p1);
            r_p2_a  <= r_p1_a;
            r_p2_b  <= r_p1_b;
            r_p2_c  <= r_p1_c;
            r_p2_h  <= r_p1_h;
            r_p3_ah <= r_p2_a * r_p2_hh;
            r_p3_bh <= r_p2_b * r_p2_h;
            r_p3_c  <= r_p2_c;
            r_p4_qa <= qsat(r_p3_ah);
            r_p4_qb <= qsat(r_p3_bh);
            r_p4_c  <= r_p3_c;
            r_p5_s  <= sat33(33'(r_p4_qa) + 33'(r_p4_qb));
            r_p5_c  <= r_p4_c;
            r_p6_poly <= sat33(33'(r_p5_s) + 33'(r_p5_c));
            r_pd[0] <= r_p6_poly;
            for (int i = 1; i < PD_N; i++) begin
                r_pd[i] <= r_pd[i-1];
            end
        end
    end

    // Apply the correction term to the time
    always_comb begin
        n_f1_side = r_side[INV_LAT-1];
        unique case (n_f1_side.mode)
            MODE_ISQ: begin
                n_f1_mid = n_f1_side.rev ? sat33(33'(n_f1_side.t) + 33'(inv_term))
                                         : sat33(33'(n_f1_side.t) - 33'(inv_term));
            end
            MODE_POLY: begin
                n_f1_mid = n_f1_side.rev ? sat33(33'(n_f1_side.t) + 33'(r_pd[PD_N-1]))
                                         : sat33(33'(n_f1_side.t) - 33'(r_pd[PD_N-1]));
            end
            default: begin
                n_f1_mid = n_f1_side.t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= r_side_v[INV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_side <= n_f1_side;
            r_f1_mid  <= n_f1_mid;
        end
    end

    // Add or drop the constant term of the inverse square root form
    always_comb begin
        if (r_f1_side.mode == MODE_ISQ) begin
            n_out_time = r_f1_side.rev ? sat33(33'(r_f1_mid) - 33'(r_f1_side.c))
                                       : sat33(33'(r_f1_mid) + 33'(r_f1_side.c));
        end else begin
            n_out_time = r_f1_mid;
        end
    end

    // Output register, held while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_time  <= n_out_time;
            r_out_found <= r_f1_side.found;
            r_out_unk   <= r_f1_side.unk;
            r_out_full  <= r_f1_side.full;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_corrected_time = r_out_time;
    assign o_found          = r_out_found;
    assign o_unknown_type   = r_out_unk;
    assign o_table_full     = r_out_full;

    // Checks
    `CTWC_ASSERT_ALWAYS(a_key_unique, i_clk, i_rst_n, $onehot0(hit_vec))
    `CTWC_ASSERT_IMPLY(a_unk_found, i_clk, i_rst_n, r_out_valid && r_out_unk, r_out_found)
    `CTWC_ASSERT_IMPLY(a_full_result, i_clk, i_rst_n, r_out_valid && r_out_full, !r_out_found && r_out_time == '0)
    `CTWC_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, accept && is_load && load_ok, r_ent_valid[$past(wr_idx)])

endmodule
`default_nettype wire

/* tb/sv/channel_time_walk_correction_tb.sv */
// Self-checking testbench for the channel time-walk correction table.
// Depends on ctwc_pkg and the channel_time_walk_correction RTL; predicts every result beat.
`default_nettype none
module channel_time_walk_correction_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctwc_pkg::*;

    localparam int  NSLOT      = 64;
    localparam int  POOL       = 60;
    localparam int  DRAIN      = 40;
    localparam int  LIMIT      = 400000;
    localparam int  IDLE_PCT   = 26;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam longint QMAX    = 64'sd2147483647;
    localparam longint QMIN    = -64'sd2147483648;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  chan;
        logic [7:0]  plane;
        logic [9:0]  seg;
        logic [1:0]  side;
        logic [1:0]  ctype;
        logic [31:0] a, b, c, t, h;
    } hit_beat_t;

    typedef struct {
        logic [31:0] ctime;
        logic        found;
        logic        unk;
        logic        full;
    } corr_result_t;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_action;
    logic [7:0]  i_channel_id, i_plane_id;
    logic [9:0]  i_segment;
    logic [1:0]  i_side, i_corr_type;
    logic signed [31:0] i_coef_a, i_coef_b, i_coef_c, i_time_value, i_pulse_height;
    logic        o_valid, i_stall;
    logic signed [31:0] o_corrected_time;
    logic        o_found, o_unknown_type, o_table_full;

    // Shadow copy of the correction table
    bit          slot_used [NSLOT];
    logic [28:0] slot_key  [NSLOT];
    logic [1:0]  slot_type [NSLOT];
    longint      slot_a [NSLOT], slot_b [NSLOT], slot_c [NSLOT];

    corr_result_t pending_results[$];
    logic [28:0]  key_pool[POOL];
    int  mismatches = 0;
    int  cycles     = 0;
    int  beats_sent = 0;
    int  beats_seen = 0;
    int  full_seen  = 0;
    int  hold_cycles = 0;
    bit  calm = 0;

    channel_time_walk_correction DUT (.*);

    // Clock: 4 ns period
    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // Abort on runaway
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint q16_mul(input longint x, input longint y);
        return sat32((x * y) >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // a / sqrt(|d|) in Q16.16, clipped; zero difference counts as one LSB
    function automatic longint walk_term(input longint a, input longint d);
        longint unsigned md, s, ma, q;
        md = (d < 0) ? -d : d;
        if (md == 0) md = 1;
        s  = int_sqrt(md << 16);
        ma = (a < 0) ? -a : a;
        q  = (ma << 16) / s;
        if (a < 0) return (q > 64'h8000_0000) ? QMIN : -longint'(q);
        return (q > 64'h7FFF_FFFF) ? QMAX : longint'(q);
    endfunction

    function automatic int find_slot(input logic [28:0] key);
        for (int i = 0; i < NSLOT; i++)
            if (slot_used[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    // Apply one beat to the shadow table and return its result
    function automatic corr_result_t correct_time(input hit_beat_t bt);
        corr_result_t r;
        logic [28:0]  key;
        int           idx;
        longint       t, h, q, poly;
        key = {bt.side, bt.plane, bt.chan, 1'b0, bt.seg};
        t   = longint'(signed'(bt.t));
        h   = longint'(signed'(bt.h));
        r   = '{32'd0, 1'b0, 1'b0, 1'b0};
        if (bt.act == ACT_LOAD) begin
            idx = find_slot(key);
            if (idx < 0)
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_used[i]) begin idx = i; break; end
            if (idx < 0) begin
                r.full = 1'b1;
            end else begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = key;
                slot_type[idx] = bt.ctype;
                slot_a[idx] = longint'(signed'(bt.a));
                slot_b[idx] = longint'(signed'(bt.b));
                slot_c[idx] = longint'(signed'(bt.c));
                r.found = 1'b1;
            end
        end else if (bt.act == ACT_FWD || bt.act == ACT_REV) begin
            idx = find_slot(key);
            r.ctime = bt.t;
            if (idx >= 0) begin
                r.found = 1'b1;
                case (slot_type[idx])
                    TYPE_ISQ: begin
                        q = walk_term(slot_a[idx], h - slot_b[idx]);
                        if (bt.act == ACT_REV) t = sat32(sat32(t + q) - slot_c[idx]);
                        else                   t = sat32(sat32(t - q) + slot_c[idx]);
                        r.ctime = t[31:0];
                    end
                    TYPE_POLY: begin
                        poly = sat32(sat32(q16_mul(slot_a[idx], q16_mul(h, h))
                                     + q16_mul(slot_b[idx], h)) + slot_c[idx]);
                        t = (bt.act == ACT_REV) ? sat32(t + poly) : sat32(t - poly);
                        r.ctime = t[31:0];
                    end
                    TYPE_UNSUP: r.unk = 1'b1;
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %h want %h", beats_seen, what, got, want);
    endtask

    // Result side: check accepted beats, then choose the next stall
    always @(posedge i_clk) begin
        corr_result_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat", o_corrected_time, 32'd0);
            end else begin
                w = pending_results.pop_front();
                if (o_corrected_time !== w.ctime) report("time", o_corrected_time, w.ctime);
                if (o_found !== w.found)
                    report("found", 32'(o_found), 32'(w.found));
                if (o_unknown_type !== w.unk)
                    report("unknown_type", 32'(o_unknown_type), 32'(w.unk));
                if (o_table_full !== w.full)
                    report("table_full", 32'(o_table_full), 32'(w.full));
                if (o_table_full === 1'b1) full_seen++;
            end
            beats_seen++;
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offer one beat, idling first at random; leave valid high on return
    task automatic send_beat(input hit_beat_t bt);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= bt.act;
        i_channel_id   <= bt.chan;
        i_plane_id     <= bt.plane;
        i_segment      <= bt.seg;
        i_side         <= bt.side;
        i_corr_type    <= bt.ctype;
        i_coef_a       <= bt.a;
        i_coef_b       <= bt.b;
        i_coef_c       <= bt.c;
        i_time_value   <= bt.t;
        i_pulse_height <= bt.h;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(correct_time(bt));
        beats_sent++;
    endtask

    function automatic hit_beat_t make_beat(input logic [1:0] act, input logic [28:0] key,
            input logic [1:0] ty, input logic [31:0] a, input logic [31:0] b,
            input logic [31:0] c, input logic [31:0] t, input logic [31:0] h);
        hit_beat_t bt;
        bt.act = act; bt.ctype = ty;
        bt.side = key[28:27]; bt.plane = key[26:19]; bt.chan = key[18:11]; bt.seg = key[9:0];
        bt.a = a; bt.b = b; bt.c = c; bt.t = t; bt.h = h;
        return bt;
    endfunction

    function automatic logic [28:0] rand_key();
        return {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b0, 10'($urandom_range(0, 1023))};
    endfunction

    // Mix of full-range, small, moderate and extreme Q16.16 values
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1 << 19) - (1 << 18);
            2: return $urandom_range(0, 1 << 25) - (1 << 24);
            3: case ($urandom_range(0, 3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return $urandom_range(0, 1 << 22);
        endcase
    endfunction

    task automatic test_directed();
        logic [28:0] k0, k1, k2, k3, kmiss;
        k0 = {2'd0, 8'd0, 8'd0, 1'b0, 10'd0};
        k1 = {2'd3, 8'hFF, 8'hFF, 1'b0, 10'h3FF};
        k2 = {2'd1, 8'hA5, 8'h5A, 1'b0, 10'h155};
        k3 = {2'd2, 8'h0F, 8'hF0, 1'b0, 10'h2AA};
        kmiss = {2'd3, 8'hFF, 8'hFF, 1'b0, 10'h3FE};
        send_beat(make_beat(ACT_LOAD, k0, TYPE_NONE, 32'h1, 32'h2, 32'h3, '0, '0));
        send_beat(make_beat(ACT_FWD,  k0, TYPE_NONE, '0, '0, '0, 32'h7FFF_FFFF,
                            32'h8000_0000));
        send_beat(make_beat(ACT_LOAD, k1, TYPE_ISQ, 32'h0001_0000, 32'h0005_0000,
                            32'h0000_8000, '0, '0));
        // zero difference: pulse height equal to b
        send_beat(make_beat(ACT_FWD, k1, TYPE_NONE, '0, '0, '0, 32'h0010_0000,
                            32'h0005_0000));
        send_beat(make_beat(ACT_REV, k1, TYPE_NONE, '0, '0, '0, 32'h0010_0000,
                            32'h0009_0000));
        send_beat(make_beat(ACT_LOAD, k2, TYPE_POLY, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, '0, '0));
        send_beat(make_beat(ACT_FWD, k2, TYPE_NONE, '0, '0, '0, 32'h8000_0000,
                            32'h7FFF_FFFF));
        send_beat(make_beat(ACT_REV, k2, TYPE_NONE, '0, '0, '0, 32'h7FFF_FFFF,
                            32'h8000_0000));
        send_beat(make_beat(ACT_LOAD, k3, TYPE_UNSUP, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_beat(make_beat(ACT_FWD, k3, TYPE_NONE, '0, '0, '0, 32'h1234_5678, 32'h1));
        send_beat(make_beat(ACT_REV, kmiss, TYPE_NONE, '0, '0, '0, 32'h8000_0000, 32'h5));
        // overwrite in place, then use the new coefficients
        send_beat(make_beat(ACT_LOAD, k1, TYPE_POLY, 32'h0000_4000, 32'hFFFF_0000,
                            32'h0002_0000, '0, '0));
        send_beat(make_beat(ACT_REV, k1, TYPE_NONE, '0, '0, '0, 32'h0000_1000,
                            32'h0003_0000));
        send_beat(make_beat(ACT_NONE, k1, TYPE_UNSUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_LOAD, k1, TYPE_ISQ, 32'h8000_0000, 32'h0,
                            32'h8000_0000, '0, '0));
        send_beat(make_beat(ACT_FWD, k1, TYPE_NONE, '0, '0, '0, 32'h8000_0000,
                            32'h8000_0000));
        send_beat(make_beat(ACT_REV, k1, TYPE_NONE, '0, '0, '0, 32'h7FFF_FFFF, 32'h0));
        send_beat(make_beat(ACT_FWD, k1, TYPE_NONE, '0, '0, '0, 32'h0, 32'h0));
    endtask

    // Mostly loads and lookups on a pool of keys, some stray keys and unused actions
    task automatic test_random(input int count);
        logic [28:0] key;
        logic [1:0]  act;
        int          pick;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 2) && (n < count / 2 + 200);
            pick = $urandom_range(0, 99);
            act  = (pick < 30) ? ACT_LOAD : (pick < 64) ? ACT_FWD : (pick < 98) ? ACT_REV
                                                                     : ACT_NONE;
            key  = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, POOL - 1)]
                                                : rand_key();
            if ($urandom_range(0, 3) == 0) key[10] = 1'b0;
            send_beat(make_beat(act, key, 2'($urandom_range(0, 3)), rand_q16(), rand_q16(),
                                rand_q16(), rand_q16(), rand_q16()));
        end
        calm = 0;
    endtask

    // Hold the result side off while beats keep coming, so the pipe fills
    task automatic test_backpressure();
        hold_cycles = 250;
        for (int n = 0; n < 150; n++)
            send_beat(make_beat(2'($urandom_range(1, 2)),
                                key_pool[$urandom_range(0, POOL - 1)],
                                TYPE_NONE, '0, '0, '0, rand_q16(), rand_q16()));
    endtask

    // Load fresh keys, each followed by a lookup of it, enough to make the table refuse them
    task automatic test_table_full();
        logic [28:0] key;
        for (int n = 0; n < 80; n++) begin
            key = rand_key();
            send_beat(make_beat(ACT_LOAD, key, 2'($urandom_range(0, 3)), rand_q16(),
                                rand_q16(), rand_q16(), '0, '0));
            send_beat(make_beat(ACT_FWD, key, TYPE_NONE, '0, '0, '0, rand_q16(),
                                rand_q16()));
        end
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_action = '0; i_channel_id = '0; i_plane_id = '0; i_segment = '0; i_side = '0;
        i_corr_type = '0; i_coef_a = '0; i_coef_b = '0; i_coef_c = '0;
        i_time_value = '0; i_pulse_height = '0;
        for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
        for (int i = 0; i < POOL; i++) key_pool[i] = rand_key();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1550);
        test_backpressure();
        test_table_full();
        i_valid <= 1'b0;

        // Drain, then allow for stray beats
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_results.size());
        end
        $display("sent %0d beats (loads, lookups, overwrites, refusals), checked %0d results",
                 beats_sent, beats_seen);
        $display("table-full refusals seen: %0d, mismatches: %0d", full_seen, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
